>>> design/trc_pkg.sv
`timescale 1ns / 1ps
// shared types, register indexes and reset constants for the thermostat relay controller
package trc_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int TEMP_WIDTH_DEF    = 12;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int SECONDS_OUT_W     = 16;
    localparam int CAUSE_W           = 3;

    // freeze protection releases 2 degrees above the threshold
    localparam int FREEZE_RELEASE = 32;

    localparam logic [9:0]  TARGET_TEMP_RST      = 10'd352;
    localparam logic [5:0]  HYSTERESIS_RST       = 6'd8;
    localparam logic [9:0]  FREEZE_THRESHOLD_RST = 10'd80;
    localparam logic [15:0] MIN_CYCLE_RST        = 16'd0;
    localparam logic [15:0] MAX_RUNTIME_RST      = 16'd3600;
    localparam logic [15:0] COOLDOWN_RST         = 16'd300;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_TEMP      = 3'd0,
        REG_HYSTERESIS       = 3'd1,
        REG_FREEZE_THRESHOLD = 3'd2,
        REG_MIN_CYCLE        = 3'd3,
        REG_MAX_RUNTIME      = 3'd4,
        REG_COOLDOWN         = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_MANUAL = 2'd2,
        FUNC_MODE   = 2'd3
    } func_t;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE          = 3'd0,
        CAUSE_AUTO_SWITCH   = 3'd1,
        CAUSE_FREEZE_ON     = 3'd2,
        CAUSE_MAX_RUNTIME   = 3'd3,
        CAUSE_MANUAL        = 3'd4,
        CAUSE_AUTO_REFUSED  = 3'd5,
        CAUSE_MANUAL_REFUSED = 3'd6
    } cause_t;

    typedef struct packed {
        logic [9:0]  target_temp;
        logic [5:0]  hysteresis;
        logic [9:0]  freeze_threshold;
        logic [15:0] min_cycle_seconds;
        logic [15:0] max_runtime_seconds;
        logic [15:0] cooldown_seconds;
    } cfg_t;

    typedef struct packed {
        logic   relay_out;
        logic   auto_mode;
        logic   freeze_flag;
        logic   cooldown_flag;
        logic   cycle_locked;
        logic   changed;
        cause_t cause;
    } flags_t;

endpackage

>>> design/trc_cfg_regs.sv
`timescale 1ns / 1ps
// configuration register file written through the plain write port
module trc_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [trc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [trc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output trc_pkg::cfg_t                    cfg
);

    trc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_temp         <= trc_pkg::TARGET_TEMP_RST;
            cfg_reg.hysteresis          <= trc_pkg::HYSTERESIS_RST;
            cfg_reg.freeze_threshold    <= trc_pkg::FREEZE_THRESHOLD_RST;
            cfg_reg.min_cycle_seconds   <= trc_pkg::MIN_CYCLE_RST;
            cfg_reg.max_runtime_seconds <= trc_pkg::MAX_RUNTIME_RST;
            cfg_reg.cooldown_seconds    <= trc_pkg::COOLDOWN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                trc_pkg::REG_TARGET_TEMP:      cfg_reg.target_temp         <= cfg_data[9:0];
                trc_pkg::REG_HYSTERESIS:       cfg_reg.hysteresis          <= cfg_data[5:0];
                trc_pkg::REG_FREEZE_THRESHOLD: cfg_reg.freeze_threshold    <= cfg_data[9:0];
                trc_pkg::REG_MIN_CYCLE:        cfg_reg.min_cycle_seconds   <= cfg_data;
                trc_pkg::REG_MAX_RUNTIME:      cfg_reg.max_runtime_seconds <= cfg_data;
                trc_pkg::REG_COOLDOWN:         cfg_reg.cooldown_seconds    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/trc_update.sv
`timescale 1ns / 1ps
// next-state and result logic for one transaction
module trc_update
#(
    parameter int COUNTER_WIDTH = trc_pkg::COUNTER_WIDTH_DEF,
    parameter int TEMP_WIDTH    = trc_pkg::TEMP_WIDTH_DEF
)
(
    input  trc_pkg::cfg_t                    cfg,
    input  logic [1:0]                       func,
    input  logic signed [TEMP_WIDTH-1:0]     temperature,
    input  logic                             temp_valid,
    input  logic                             manual_on,
    input  logic                             mode_select,
    input  logic                             relay,
    input  logic                             mode_auto,
    input  logic                             freeze,
    input  logic                             cooldown,
    input  logic [COUNTER_WIDTH-1:0]         on_secs,
    input  logic [COUNTER_WIDTH-1:0]         off_secs,
    input  logic [COUNTER_WIDTH-1:0]         cool_secs,
    input  logic signed [TEMP_WIDTH-1:0]     stored_temp,
    output logic                             relay_next,
    output logic                             mode_auto_next,
    output logic                             freeze_next,
    output logic                             cooldown_next,
    output logic [COUNTER_WIDTH-1:0]         on_secs_next,
    output logic [COUNTER_WIDTH-1:0]         off_secs_next,
    output logic [COUNTER_WIDTH-1:0]         cool_secs_next,
    output logic signed [TEMP_WIDTH-1:0]     stored_temp_next,
    output trc_pkg::flags_t                  flags,
    output logic [trc_pkg::SECONDS_OUT_W-1:0] state_seconds
);

    localparam int SEC_W = (COUNTER_WIDTH > trc_pkg::SECONDS_OUT_W) ?
                           COUNTER_WIDTH : trc_pkg::SECONDS_OUT_W;
    localparam int CMP_W = ((TEMP_WIDTH > 12) ? TEMP_WIDTH : 12) + 1;

    logic signed [CMP_W-1:0] t_ext;
    logic signed [CMP_W-1:0] ft_ext;
    logic signed [CMP_W-1:0] release_ext;
    logic signed [CMP_W-1:0] tgt_ext;
    logic signed [CMP_W-1:0] hyst_ext;
    logic signed [CMP_W-1:0] band_lo;
    logic signed [CMP_W-1:0] band_hi;
    logic [SEC_W-1:0]        secs_wide;
    logic [SEC_W-1:0]        out_max;

    function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] c);
        sat_inc = (&c) ? c : c + COUNTER_WIDTH'(1);
    endfunction

    function automatic logic is_locked(input logic r, input logic [COUNTER_WIDTH-1:0] on_c,
                                       input logic [COUNTER_WIDTH-1:0] off_c,
                                       input logic [15:0] min_c);
        logic [SEC_W-1:0] s;
        s = r ? SEC_W'(on_c) : SEC_W'(off_c);
        is_locked = (min_c != 16'd0) && (s < SEC_W'(min_c));
    endfunction

    assign t_ext       = CMP_W'(temperature);
    assign ft_ext      = CMP_W'($signed(cfg.freeze_threshold));
    assign release_ext = ft_ext + CMP_W'(trc_pkg::FREEZE_RELEASE);
    assign tgt_ext     = CMP_W'($signed({1'b0, cfg.target_temp}));
    assign hyst_ext    = CMP_W'($signed({1'b0, cfg.hysteresis}));
    assign band_lo     = tgt_ext - hyst_ext;
    assign band_hi     = tgt_ext + hyst_ext;
    assign out_max     = SEC_W'({trc_pkg::SECONDS_OUT_W{1'b1}});

    always_comb
    begin
        logic want;
        trc_pkg::cause_t cause;

        relay_next       = relay;
        mode_auto_next   = mode_auto;
        freeze_next      = freeze;
        cooldown_next    = cooldown;
        on_secs_next     = on_secs;
        off_secs_next    = off_secs;
        cool_secs_next   = cool_secs;
        stored_temp_next = stored_temp;
        cause            = trc_pkg::CAUSE_NONE;
        want             = relay;

        case (func)
            trc_pkg::FUNC_TICK:
            begin
                if (relay)
                    on_secs_next = sat_inc(on_secs);
                else
                    off_secs_next = sat_inc(off_secs);
                if (cooldown)
                begin
                    cool_secs_next = sat_inc(cool_secs);
                    if (SEC_W'(cool_secs_next) >= SEC_W'(cfg.cooldown_seconds))
                        cooldown_next = 1'b0;
                end
                else if (relay && (SEC_W'(on_secs_next) >= SEC_W'(cfg.max_runtime_seconds)))
                begin
                    relay_next     = 1'b0;
                    off_secs_next  = '0;
                    cooldown_next  = 1'b1;
                    cool_secs_next = '0;
                    cause          = trc_pkg::CAUSE_MAX_RUNTIME;
                end
            end
            trc_pkg::FUNC_SAMPLE:
            begin
                if (temp_valid)
                begin
                    stored_temp_next = temperature;
                    if (t_ext < ft_ext)
                    begin
                        freeze_next = 1'b1;
                        if (!relay)
                        begin
                            relay_next   = 1'b1;
                            on_secs_next = '0;
                            cause        = trc_pkg::CAUSE_FREEZE_ON;
                        end
                    end
                    else if (freeze && (t_ext > release_ext))
                    begin
                        freeze_next = 1'b0;
                    end
                    // freeze not active here means the relay was left untouched above
                    if (!freeze_next && !cooldown && mode_auto)
                    begin
                        if (t_ext < band_lo)
                            want = 1'b1;
                        else if (t_ext > band_hi)
                            want = 1'b0;
                        if (want != relay)
                        begin
                            if (is_locked(relay, on_secs, off_secs, cfg.min_cycle_seconds))
                            begin
                                cause = trc_pkg::CAUSE_AUTO_REFUSED;
                            end
                            else
                            begin
                                relay_next = want;
                                if (want)
                                    on_secs_next = '0;
                                else
                                    off_secs_next = '0;
                                cause = trc_pkg::CAUSE_AUTO_SWITCH;
                            end
                        end
                    end
                end
            end
            trc_pkg::FUNC_MANUAL:
            begin
                mode_auto_next = 1'b0;
                if (manual_on)
                begin
                    if (cooldown)
                    begin
                        cause = trc_pkg::CAUSE_MANUAL_REFUSED;
                    end
                    else if (!relay)
                    begin
                        relay_next   = 1'b1;
                        on_secs_next = '0;
                        cause        = trc_pkg::CAUSE_MANUAL;
                    end
                end
                else if (relay)
                begin
                    relay_next    = 1'b0;
                    off_secs_next = '0;
                    cause         = trc_pkg::CAUSE_MANUAL;
                end
            end
            trc_pkg::FUNC_MODE:
            begin
                mode_auto_next = mode_select;
            end
            default: ;
        endcase

        flags.relay_out     = relay_next;
        flags.auto_mode     = mode_auto_next;
        flags.freeze_flag   = freeze_next;
        flags.cooldown_flag = cooldown_next;
        flags.cycle_locked  = is_locked(relay_next, on_secs_next, off_secs_next,
                                        cfg.min_cycle_seconds);
        flags.changed       = relay_next != relay;
        flags.cause         = cause;
    end

    assign secs_wide     = relay_next ? SEC_W'(on_secs_next) : SEC_W'(off_secs_next);
    assign state_seconds = (secs_wide > out_max) ? {trc_pkg::SECONDS_OUT_W{1'b1}}
                                                 : secs_wide[trc_pkg::SECONDS_OUT_W-1:0];

endmodule

>>> design/thermostat_relay_controller.sv
`timescale 1ns / 1ps
// an accepted transaction is held in the input register until it moves to the result register
// throughput: one transaction per cycle unless stalled; input register feeds the update logic
// the next-state logic is combinational and closes on the controller state registers
// while a result waits, the input register can still take one transaction if it is empty
// reset: relay off, auto mode, freeze, cooldown and counters cleared, registers at defaults
module thermostat_relay_controller
#(
    parameter int COUNTER_WIDTH = trc_pkg::COUNTER_WIDTH_DEF,
    parameter int TEMP_WIDTH    = trc_pkg::TEMP_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [trc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [trc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       func,
    input  logic signed [TEMP_WIDTH-1:0]     temperature,
    input  logic                             temp_valid,
    input  logic                             manual_on,
    input  logic                             mode_select,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             relay_out,
    output logic                             auto_mode,
    output logic                             freeze_flag,
    output logic                             cooldown_flag,
    output logic                             cycle_locked,
    output logic                             changed,
    output logic [trc_pkg::CAUSE_W-1:0]      cause,
    output logic [trc_pkg::SECONDS_OUT_W-1:0] state_seconds,
    output logic signed [TEMP_WIDTH-1:0]     last_temperature
);

    trc_pkg::cfg_t cfg;

    // input stage
    logic                          in_full_reg;
    logic [1:0]                    func_reg;
    logic signed [TEMP_WIDTH-1:0]  temp_reg;
    logic                          temp_valid_reg;
    logic                          manual_on_reg;
    logic                          mode_select_reg;

    // controller state
    logic                          relay_reg;
    logic                          mode_auto_reg;
    logic                          freeze_reg;
    logic                          cooldown_reg;
    logic [COUNTER_WIDTH-1:0]      on_secs_reg;
    logic [COUNTER_WIDTH-1:0]      off_secs_reg;
    logic [COUNTER_WIDTH-1:0]      cool_secs_reg;
    logic signed [TEMP_WIDTH-1:0]  stored_temp_reg;

    logic                          relay_next;
    logic                          mode_auto_next;
    logic                          freeze_next;
    logic                          cooldown_next;
    logic [COUNTER_WIDTH-1:0]      on_secs_next;
    logic [COUNTER_WIDTH-1:0]      off_secs_next;
    logic [COUNTER_WIDTH-1:0]      cool_secs_next;
    logic signed [TEMP_WIDTH-1:0]  stored_temp_next;
    trc_pkg::flags_t               flags_next;
    logic [trc_pkg::SECONDS_OUT_W-1:0] secs_next;

    // result register
    logic                          out_valid_reg;
    trc_pkg::flags_t               flags_reg;
    logic [trc_pkg::SECONDS_OUT_W-1:0] secs_reg;
    logic signed [TEMP_WIDTH-1:0]  last_temp_reg;

    logic                          advance;
    logic                          in_take;

    trc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trc_update
    #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .TEMP_WIDTH    (TEMP_WIDTH)
    )
    u_update
    (
        .cfg              (cfg),
        .func             (func_reg),
        .temperature      (temp_reg),
        .temp_valid       (temp_valid_reg),
        .manual_on        (manual_on_reg),
        .mode_select      (mode_select_reg),
        .relay            (relay_reg),
        .mode_auto        (mode_auto_reg),
        .freeze           (freeze_reg),
        .cooldown         (cooldown_reg),
        .on_secs          (on_secs_reg),
        .off_secs         (off_secs_reg),
        .cool_secs        (cool_secs_reg),
        .stored_temp      (stored_temp_reg),
        .relay_next       (relay_next),
        .mode_auto_next   (mode_auto_next),
        .freeze_next      (freeze_next),
        .cooldown_next    (cooldown_next),
        .on_secs_next     (on_secs_next),
        .off_secs_next    (off_secs_next),
        .cool_secs_next   (cool_secs_next),
        .stored_temp_next (stored_temp_next),
        .flags            (flags_next),
        .state_seconds    (secs_next)
    );

    // the held transaction moves on when the result register is free or being emptied
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg        <= func;
            temp_reg        <= temperature;
            temp_valid_reg  <= temp_valid;
            manual_on_reg   <= manual_on;
            mode_select_reg <= mode_select;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg       <= 1'b0;
            mode_auto_reg   <= 1'b1;
            freeze_reg      <= 1'b0;
            cooldown_reg    <= 1'b0;
            on_secs_reg     <= '0;
            off_secs_reg    <= '0;
            cool_secs_reg   <= '0;
            stored_temp_reg <= '0;
        end
        else if (advance)
        begin
            relay_reg       <= relay_next;
            mode_auto_reg   <= mode_auto_next;
            freeze_reg      <= freeze_next;
            cooldown_reg    <= cooldown_next;
            on_secs_reg     <= on_secs_next;
            off_secs_reg    <= off_secs_next;
            cool_secs_reg   <= cool_secs_next;
            stored_temp_reg <= stored_temp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flags_reg     <= flags_next;
            secs_reg      <= secs_next;
            last_temp_reg <= stored_temp_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign relay_out        = flags_reg.relay_out;
    assign auto_mode        = flags_reg.auto_mode;
    assign freeze_flag      = flags_reg.freeze_flag;
    assign cooldown_flag    = flags_reg.cooldown_flag;
    assign cycle_locked     = flags_reg.cycle_locked;
    assign changed          = flags_reg.changed;
    assign cause            = flags_reg.cause;
    assign state_seconds    = secs_reg;
    assign last_temperature = last_temp_reg;

endmodule

>>> sim/tb_thermostat_relay_controller.sv
`timescale 1ns / 1ps
// self-checking testbench for the thermostat relay controller: directed table, random phases
module tb_thermostat_relay_controller;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_SEGS    = 8;
    localparam int SEG_ITEMS   = 175;

    typedef struct {
        trc_pkg::func_t     fn;
        logic signed [11:0] temp;
        logic               tvalid;
        logic               man_on;
        logic               mode_sel;
    } stim_t;

    typedef struct {
        logic               relay;
        logic               mode_auto;
        logic               freeze;
        logic               cooling;
        logic               locked;
        logic               changed;
        trc_pkg::cause_t    cause;
        logic [15:0]        seconds;
        logic signed [11:0] temp;
    } status_t;

    typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        trc_pkg::reg_index_t idx;
        logic [15:0]         data;
        stim_t               item;
        bit                  typed;
        status_t             want;
    } dir_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_write;
    logic [trc_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [trc_pkg::CFG_DATA_W-1:0]    cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic [1:0]                        func;
    logic signed [11:0]                temperature;
    logic                              temp_valid;
    logic                              manual_on;
    logic                              mode_select;
    logic                              out_valid;
    logic                              out_stall;
    logic                              relay_out;
    logic                              auto_mode;
    logic                              freeze_flag;
    logic                              cooldown_flag;
    logic                              cycle_locked;
    logic                              changed;
    logic [trc_pkg::CAUSE_W-1:0]       cause;
    logic [trc_pkg::SECONDS_OUT_W-1:0] state_seconds;
    logic signed [11:0]                last_temperature;

    // predictor copy of the controller
    trc_pkg::cfg_t      live_cfg;
    logic               relay_st;
    logic               auto_st;
    logic               freeze_st;
    logic               cooling_st;
    logic [15:0]        on_secs;
    logic [15:0]        off_secs;
    logic [15:0]        cool_secs;
    logic signed [11:0] last_temp;

    status_t pending_status[$];
    int      mismatches;
    int      status_checked;
    int      items_sent;
    int      cfg_loads;
    int      idle_pct;
    int      stall_pct;
    int      hold_req;
    int      cycle_count;

    thermostat_relay_controller i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .temperature      (temperature),
        .temp_valid       (temp_valid),
        .manual_on        (manual_on),
        .mode_select      (mode_select),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .relay_out        (relay_out),
        .auto_mode        (auto_mode),
        .freeze_flag      (freeze_flag),
        .cooldown_flag    (cooldown_flag),
        .cycle_locked     (cycle_locked),
        .changed          (changed),
        .cause            (cause),
        .state_seconds    (state_seconds),
        .last_temperature (last_temperature)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [15:0] sat_inc(logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic logic cycle_lock();
        if (live_cfg.min_cycle_seconds == 16'd0)
            return 1'b0;
        return (relay_st ? on_secs : off_secs) < live_cfg.min_cycle_seconds;
    endfunction

    function automatic void switch_relay(logic on);
        relay_st = on;
        if (on)
            on_secs = 16'd0;
        else
            off_secs = 16'd0;
    endfunction

    function automatic status_t predict_relay_status(stim_t s);
        status_t r;
        logic    prev;
        logic    want;
        int      t;
        int      thr;
        int      tgt;
        int      h;
        r.cause = trc_pkg::CAUSE_NONE;
        prev = relay_st;
        thr = int'($signed(live_cfg.freeze_threshold));
        tgt = int'(live_cfg.target_temp);
        h = int'(live_cfg.hysteresis);
        case (s.fn)
            trc_pkg::FUNC_TICK:
            begin
                if (relay_st)
                    on_secs = sat_inc(on_secs);
                else
                    off_secs = sat_inc(off_secs);
                if (cooling_st)
                begin
                    cool_secs = sat_inc(cool_secs);
                    if (cool_secs >= live_cfg.cooldown_seconds)
                        cooling_st = 1'b0;
                end
                else if (relay_st && on_secs >= live_cfg.max_runtime_seconds)
                begin
                    switch_relay(1'b0);
                    cooling_st = 1'b1;
                    cool_secs = 16'd0;
                    r.cause = trc_pkg::CAUSE_MAX_RUNTIME;
                end
            end
            trc_pkg::FUNC_SAMPLE:
            begin
                if (s.tvalid)
                begin
                    t = int'(s.temp);
                    last_temp = s.temp;
                    if (t < thr)
                    begin
                        freeze_st = 1'b1;
                        if (!relay_st)
                        begin
                            switch_relay(1'b1);
                            r.cause = trc_pkg::CAUSE_FREEZE_ON;
                        end
                    end
                    else if (freeze_st && t > thr + trc_pkg::FREEZE_RELEASE)
                        freeze_st = 1'b0;
                    if (!freeze_st && !cooling_st && auto_st)
                    begin
                        want = relay_st;
                        if (t < tgt - h)
                            want = 1'b1;
                        else if (t > tgt + h)
                            want = 1'b0;
                        if (want != relay_st)
                        begin
                            if (cycle_lock())
                                r.cause = trc_pkg::CAUSE_AUTO_REFUSED;
                            else
                            begin
                                switch_relay(want);
                                r.cause = trc_pkg::CAUSE_AUTO_SWITCH;
                            end
                        end
                    end
                end
            end
            trc_pkg::FUNC_MANUAL:
            begin
                auto_st = 1'b0;
                if (s.man_on)
                begin
                    if (cooling_st)
                        r.cause = trc_pkg::CAUSE_MANUAL_REFUSED;
                    else if (!relay_st)
                    begin
                        switch_relay(1'b1);
                        r.cause = trc_pkg::CAUSE_MANUAL;
                    end
                end
                else if (relay_st)
                begin
                    switch_relay(1'b0);
                    r.cause = trc_pkg::CAUSE_MANUAL;
                end
            end
            default:
                auto_st = s.mode_sel;
        endcase
        r.relay = relay_st;
        r.mode_auto = auto_st;
        r.freeze = freeze_st;
        r.cooling = cooling_st;
        r.locked = cycle_lock();
        r.changed = (prev != relay_st);
        r.seconds = relay_st ? on_secs : off_secs;
        r.temp = last_temp;
        return r;
    endfunction

    function automatic status_t status(bit relay, bit auto_on, bit frz, bit cool, bit lock,
                                       bit chg, trc_pkg::cause_t c, int secs, int temp);
        status_t r;
        r.relay = relay;
        r.mode_auto = auto_on;
        r.freeze = frz;
        r.cooling = cool;
        r.locked = lock;
        r.changed = chg;
        r.cause = c;
        r.seconds = secs[15:0];
        r.temp = temp[11:0];
        return r;
    endfunction

    function automatic dir_row_t item_row(trc_pkg::func_t fn, int temp, bit tv, bit mon,
                                          bit msel);
        dir_row_t r;
        r.kind = ROW_ITEM;
        r.idx = trc_pkg::REG_TARGET_TEMP;
        r.data = 16'd0;
        r.item.fn = fn;
        r.item.temp = temp[11:0];
        r.item.tvalid = tv;
        r.item.man_on = mon;
        r.item.mode_sel = msel;
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic dir_row_t reg_row(trc_pkg::reg_index_t idx, logic [15:0] data);
        dir_row_t r;
        r = item_row(trc_pkg::FUNC_TICK, 0, 1'b0, 1'b0, 1'b0);
        r.kind = ROW_REG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic dir_row_t typed_row(dir_row_t r, status_t want);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    // samples cluster around the switching band and the freeze threshold
    function automatic stim_t rand_stim();
        stim_t       s;
        logic [31:0] raw;
        int          pick;
        int          v;
        int          h;
        raw = $urandom;
        s.temp = raw[11:0];
        s.tvalid = raw[12];
        s.man_on = raw[13];
        s.mode_sel = raw[14];
        h = int'(live_cfg.hysteresis);
        pick = $urandom_range(99);
        if (pick < 40)
            s.fn = trc_pkg::FUNC_TICK;
        else if (pick < 80)
        begin
            s.fn = trc_pkg::FUNC_SAMPLE;
            s.tvalid = ($urandom_range(9) != 0);
            pick = $urandom_range(9);
            if (pick < 6)
            begin
                v = int'(live_cfg.target_temp) + int'($urandom_range(0, 4 * h + 8)) - (2 * h + 4);
                s.temp = v[11:0];
            end
            else if (pick < 8)
            begin
                v = int'($signed(live_cfg.freeze_threshold)) + int'($urandom_range(0, 80)) - 30;
                s.temp = v[11:0];
            end
        end
        else if (pick < 86)
            s.fn = trc_pkg::FUNC_MANUAL;
        else
        begin
            s.fn = trc_pkg::FUNC_MODE;
            s.mode_sel = ($urandom_range(3) != 0);
        end
        return s;
    endfunction

    function automatic trc_pkg::cfg_t pick_config(int seg);
        trc_pkg::cfg_t c;
        int            v;
        case (seg)
            0:
            begin
                v = -320;
                c = {10'd80, 6'd2, v[9:0], 16'd0, 16'd1, 16'd0};
            end
            1:
                c = {10'd560, 6'd48, 10'd320, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            2:
                // beyond the documented ranges: no runtime allowed, no cooldown
                c = {10'h3FF, 6'h3F, 10'h200, 16'd1, 16'd0, 16'd0};
            default:
            begin
                v = int'($urandom_range(0, 640)) - 320;
                c.target_temp = 10'($urandom_range(80, 560));
                c.hysteresis = 6'($urandom_range(2, 48));
                c.freeze_threshold = v[9:0];
                c.min_cycle_seconds = $urandom_range(1) ? 16'd0 : 16'($urandom_range(1, 6));
                c.max_runtime_seconds = 16'($urandom_range(1, 40));
                c.cooldown_seconds = 16'($urandom_range(0, 15));
            end
        endcase
        return c;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // caller lowers cfg_write after the last write of a batch
    task automatic write_reg(trc_pkg::reg_index_t idx, logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            trc_pkg::REG_TARGET_TEMP:      live_cfg.target_temp = data[9:0];
            trc_pkg::REG_HYSTERESIS:       live_cfg.hysteresis = data[5:0];
            trc_pkg::REG_FREEZE_THRESHOLD: live_cfg.freeze_threshold = data[9:0];
            trc_pkg::REG_MIN_CYCLE:        live_cfg.min_cycle_seconds = data;
            trc_pkg::REG_MAX_RUNTIME:      live_cfg.max_runtime_seconds = data;
            trc_pkg::REG_COOLDOWN:         live_cfg.cooldown_seconds = data;
            default:                       ;
        endcase
    endtask

    task automatic load_config(trc_pkg::cfg_t c);
        drain();
        write_reg(trc_pkg::REG_TARGET_TEMP, {6'd0, c.target_temp});
        write_reg(trc_pkg::REG_HYSTERESIS, {10'd0, c.hysteresis});
        write_reg(trc_pkg::REG_FREEZE_THRESHOLD,
                  {{6{c.freeze_threshold[9]}}, c.freeze_threshold});
        write_reg(trc_pkg::REG_MIN_CYCLE, c.min_cycle_seconds);
        write_reg(trc_pkg::REG_MAX_RUNTIME, c.max_runtime_seconds);
        write_reg(trc_pkg::REG_COOLDOWN, c.cooldown_seconds);
        cfg_write <= 1'b0;
        cfg_loads++;
    endtask

    task automatic offer(stim_t s, bit typed, status_t want);
        status_t predicted;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        func <= s.fn;
        temperature <= s.temp;
        temp_valid <= s.tvalid;
        manual_on <= s.man_on;
        mode_select <= s.mode_sel;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = predict_relay_status(s);
        pending_status.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result side: checks each transaction and drives the stall pattern
    initial
    begin
        status_t want;
        int      hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_status.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    check_field("relay_out", want.relay, relay_out);
                    check_field("auto_mode", want.mode_auto, auto_mode);
                    check_field("freeze_flag", want.freeze, freeze_flag);
                    check_field("cooldown_flag", want.cooling, cooldown_flag);
                    check_field("cycle_locked", want.locked, cycle_locked);
                    check_field("changed", want.changed, changed);
                    check_field("cause", want.cause, cause);
                    check_field("state_seconds", want.seconds, state_seconds);
                    check_field("last_temperature", want.temp, last_temperature);
                    status_checked++;
                end
            end
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_status.size());
        $display("tb_thermostat_relay_controller: FAIL");
        $finish;
    end

    initial
    begin
        dir_row_t      rows[$];
        dir_row_t      row;
        trc_pkg::cfg_t c;
        stim_t         s;
        status_t       none;
        int            seg;
        int            i;

        mismatches = 0;
        status_checked = 0;
        items_sent = 0;
        cfg_loads = 0;
        idle_pct = 36;
        stall_pct = 36;
        hold_req = 0;

        live_cfg = {trc_pkg::TARGET_TEMP_RST, trc_pkg::HYSTERESIS_RST,
                    trc_pkg::FREEZE_THRESHOLD_RST, trc_pkg::MIN_CYCLE_RST,
                    trc_pkg::MAX_RUNTIME_RST, trc_pkg::COOLDOWN_RST};
        relay_st = 1'b0;
        auto_st = 1'b1;
        freeze_st = 1'b0;
        cooling_st = 1'b0;
        on_secs = 16'd0;
        off_secs = 16'd0;
        cool_secs = 16'd0;
        last_temp = 12'sd0;
        none = status(0, 0, 0, 0, 0, 0, trc_pkg::CAUSE_NONE, 0, 0);

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= trc_pkg::REG_TARGET_TEMP;
        cfg_data <= 16'd0;
        in_valid <= 1'b0;
        func <= trc_pkg::FUNC_TICK;
        temperature <= 12'sd0;
        temp_valid <= 1'b0;
        manual_on <= 1'b0;
        mode_select <= 1'b0;

        // defaults after reset, freeze entry and release, manual and mode commands
        rows.push_back(typed_row(item_row(trc_pkg::FUNC_TICK, 0, 0, 0, 0),
                       status(0, 1, 0, 0, 0, 0, trc_pkg::CAUSE_NONE, 1, 0)));
        rows.push_back(typed_row(item_row(trc_pkg::FUNC_SAMPLE, -2048, 0, 1, 1),
                       status(0, 1, 0, 0, 0, 0, trc_pkg::CAUSE_NONE, 1, 0)));
        rows.push_back(typed_row(item_row(trc_pkg::FUNC_SAMPLE, 2047, 1, 0, 0),
                       status(0, 1, 0, 0, 0, 0, trc_pkg::CAUSE_NONE, 1, 2047)));
        rows.push_back(typed_row(item_row(trc_pkg::FUNC_SAMPLE, -2048, 1, 0, 0),
                       status(1, 1, 1, 0, 0, 1, trc_pkg::CAUSE_FREEZE_ON, 0, -2048)));
        rows.push_back(item_row(trc_pkg::FUNC_SAMPLE, 100, 1, 0, 0));
        rows.push_back(item_row(trc_pkg::FUNC_SAMPLE, 113, 1, 0, 0));
        rows.push_back(item_row(trc_pkg::FUNC_TICK, 0, 0, 0, 0));
        rows.push_back(typed_row(item_row(trc_pkg::FUNC_MANUAL, 0, 0, 0, 1),
                       status(0, 0, 0, 0, 0, 1, trc_pkg::CAUSE_MANUAL, 0, 113)));
        rows.push_back(item_row(trc_pkg::FUNC_MANUAL, 0, 0, 0, 0));
        rows.push_back(item_row(trc_pkg::FUNC_MANUAL, 0, 0, 1, 0));
        rows.push_back(item_row(trc_pkg::FUNC_MODE, 0, 0, 0, 1));
        rows.push_back(item_row(trc_pkg::FUNC_SAMPLE, 400, 1, 0, 0));
        rows.push_back(item_row(trc_pkg::FUNC_MODE, 0, 0, 1, 0));
        rows.push_back(item_row(trc_pkg::FUNC_MODE, 0, 0, 0, 1));
        // short lock, runtime and cooldown so each triggers within a few ticks
        rows.push_back(reg_row(trc_pkg::REG_MIN_CYCLE, 16'd2));
        rows.push_back(reg_row(trc_pkg::REG_MAX_RUNTIME, 16'd3));
        rows.push_back(reg_row(trc_pkg::REG_COOLDOWN, 16'd2));
        rows.push_back(item_row(trc_pkg::FUNC_SAMPLE, 200, 1, 0, 0));
        rows.push_back(item_row(trc_pkg::FUNC_TICK, 0, 0, 0, 0));
        rows.push_back(item_row(trc_pkg::FUNC_TICK, 0, 0, 0, 0));
        rows.push_back(item_row(trc_pkg::FUNC_SAMPLE, 200, 1, 0, 0));
        for (i = 0; i < 3; i++)
            rows.push_back(item_row(trc_pkg::FUNC_TICK, 0, 0, 0, 0));
        rows.push_back(item_row(trc_pkg::FUNC_MANUAL, 0, 0, 1, 0));
        rows.push_back(item_row(trc_pkg::FUNC_SAMPLE, -2048, 1, 0, 0));
        rows.push_back(item_row(trc_pkg::FUNC_TICK, 0, 0, 0, 0));
        rows.push_back(item_row(trc_pkg::FUNC_TICK, 0, 0, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_REG)
            begin
                drain();
                write_reg(rows[i].idx, rows[i].data);
                cfg_write <= 1'b0;
                cfg_loads++;
            end
            else
                offer(rows[i].item, rows[i].typed, rows[i].want);
        end

        for (seg = 0; seg < NUM_SEGS; seg++)
        begin
            case (seg % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 69; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            c = pick_config(seg);
            load_config(c);
            row = item_row(trc_pkg::FUNC_MODE, 0, 0, 0, 1);
            offer(row.item, 1'b0, none);
            // long output hold-off while items keep coming, so the input side backs up
            if (seg == 0)
                hold_req = 60;
            for (i = 0; i < SEG_ITEMS; i++)
            begin
                if (i == SEG_ITEMS / 2)
                    drain();
                s = rand_stim();
                offer(s, 1'b0, none);
            end
        end

        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d transactions sent and %0d results checked over %0d register settings,",
                 items_sent, status_checked, cfg_loads);
        $display("including freeze, lock, runtime cutoff, cooldown and back-pressure cases");
        if (mismatches == 0)
            $display("tb_thermostat_relay_controller: PASS");
        else
            $display("tb_thermostat_relay_controller: FAIL");
        $finish;
    end

endmodule
